### hw/rtl/accumulator_machine_step_core_defines.svh
// Assertion macros for the top core, which checks its own logic.
`ifndef ACCUMULATOR_MACHINE_STEP_CORE_DEFINES_SVH
`define ACCUMULATOR_MACHINE_STEP_CORE_DEFINES_SVH

// A consequent that must hold in the same cycle as its trigger.
`define AMS_ASSERT_NOW(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// A consequent that must hold in the cycle after its trigger.
`define AMS_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

### hw/rtl/ams_pkg.sv
`timescale 1ns / 1ps
package ams_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned AddrW = 7;
  localparam int unsigned OpcW  = 26;
  localparam int unsigned OprW  = 8;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_EXEC    = 2'd1,
    REQ_READ    = 2'd2,
    REQ_RESTART = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HALTED  = 3'd1,
    ST_DIVZERO = 3'd2,
    ST_INVALID = 3'd3,
    ST_STOPPED = 3'd4
  } status_t;

  localparam logic [5:0] OP_READ   = 6'd10;
  localparam logic [5:0] OP_WRITE  = 6'd11;
  localparam logic [5:0] OP_LOAD   = 6'd20;
  localparam logic [5:0] OP_STORE  = 6'd21;
  localparam logic [5:0] OP_ADD    = 6'd30;
  localparam logic [5:0] OP_SUB    = 6'd31;
  localparam logic [5:0] OP_DIV    = 6'd32;
  localparam logic [5:0] OP_MUL    = 6'd33;
  localparam logic [5:0] OP_BR     = 6'd40;
  localparam logic [5:0] OP_BRNEG  = 6'd41;
  localparam logic [5:0] OP_BRZERO = 6'd42;
  localparam logic [5:0] OP_HALT   = 6'd43;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_FETCH,
    S_DECODE,
    S_OPREAD,
    S_OPWAIT,
    S_EXEC,
    S_DIVIDE,
    S_DIVDONE,
    S_DATAREAD,
    S_DATAWAIT,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the request fields
    logic clr_step;    // write zero at the sweep address and advance it
    logic rd_pc;       // read memory at the program counter
    logic rd_opr;      // read memory at the operand index
    logic wr_req;      // write the request data at the request address
    logic dec_start;   // begin the divide-by-100 decode
    logic exec;        // apply the instruction to the machine state
    logic div_start;   // begin the accumulator divide
    logic div_done;    // commit the quotient
    logic restart;     // clear accumulator, counter and halt flag
    logic fin_ok;      // finish a request with no instruction
    logic fin_read;    // finish a read request with memory data
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       stopped;
    logic       dec_busy;
    logic       div_busy;
    logic       is_div;
    logic       req_in_range;
  } sts_t;

endpackage

### hw/rtl/ams_ram.sv
`timescale 1ns / 1ps
module ams_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/ams_divider.sv
`timescale 1ns / 1ps
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module ams_divider (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [31:0]      dividend,
  input  logic signed [31:0]      divisor,
  output logic                    busy,
  output logic signed [31:0]      quotient
);
  logic [31:0] q;
  logic [32:0] r;
  logic [31:0] d;
  logic [5:0]  cnt;
  logic        neg_q;
  logic [32:0] trial;

  assign trial = {r[31:0], q[31]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q     <= dividend[31] ? (32'd0 - dividend) : dividend;
      d     <= divisor[31] ? (32'd0 - divisor) : divisor;
      r     <= '0;
      neg_q <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      if (!trial[32]) begin
        r <= trial;
        q <= {q[30:0], 1'b1};
      end else begin
        r <= {r[31:0], q[31]};
        q <= {q[30:0], 1'b0};
      end
    end
  end

  assign quotient = neg_q ? (32'd0 - q) : q;
endmodule

### hw/rtl/ams_datapath.sv
`timescale 1ns / 1ps
module ams_datapath #(
  parameter int unsigned MemoryWords = 100
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ams_pkg::cmd_t                  cmd,
  output ams_pkg::sts_t                  sts,
  input  logic [1:0]                     req_type,
  input  logic [ams_pkg::AddrW-1:0]      address,
  input  logic signed [ams_pkg::WordW-1:0] data_value,
  output logic [ams_pkg::AddrW-1:0]      pc_executed,
  output logic signed [ams_pkg::OpcW-1:0] opcode_seen,
  output logic signed [ams_pkg::OprW-1:0] operand_seen,
  output logic signed [ams_pkg::WordW-1:0] accumulator_now,
  output logic                           out_valid,
  output logic signed [ams_pkg::WordW-1:0] out_value,
  output logic [2:0]                     status
);
  import ams_pkg::*;

  localparam int unsigned MemAW = $clog2(MemoryWords);
  // Reciprocal of 100 scaled by 2^37; exact for every 32-bit magnitude.
  localparam logic [WordW-1:0] DecRecip = 32'h51EB_851F;

  logic [AddrW-1:0] req_addr;
  logic [WordW-1:0] req_data;
  logic [1:0]       req_kind;
  logic [WordW-1:0] acc;
  logic [WordW-1:0] acc_next;
  logic [AddrW-1:0] pc;
  logic [AddrW-1:0] pc_next;
  logic             halted;
  logic [MemAW-1:0] clr_addr;
  logic [MemAW-1:0] idx;
  logic signed [OpcW-1:0] opc;
  logic signed [OprW-1:0] opr;

  logic             ram_we;
  logic [MemAW-1:0] ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic [MemAW-1:0] ram_raddr;
  logic [WordW-1:0] ram_rdata;

  logic             dv_busy;
  logic signed [WordW-1:0] dv_q;
  logic [1:0]       dec_phase;
  logic             dec_neg;
  logic [WordW-1:0] dec_mag;
  logic [63:0]      dec_prod;
  logic [24:0]      dec_quo;
  logic [WordW-1:0] dec_rest;
  logic [6:0]       dec_rem;
  logic [5:0]       opc_low;
  logic [WordW-1:0] mem_opr;

  ams_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(acc), .divisor(ram_rdata),
    .busy(dv_busy), .quotient(dv_q)
  );

  ams_ram #(.Width(WordW), .Depth(MemoryWords)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign opc_low = (opc[OpcW-1:6] == '0) ? opc[5:0] : 6'd0;

  assign dec_prod = 64'(dec_mag) * 64'(DecRecip);
  assign dec_rest = dec_mag - (WordW'(dec_quo) * 32'd100);
  assign dec_rem  = 7'(dec_rest);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = req_addr[MemAW-1:0];
    ram_wdata = req_data;
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (cmd.wr_req) begin
      ram_we = sts.req_in_range;
    end else if (cmd.exec && opc_low == OP_READ) begin
      ram_we    = 1'b1;
      ram_waddr = idx;
    end else if (cmd.exec && opc_low == OP_STORE) begin
      ram_we    = 1'b1;
      ram_waddr = idx;
      ram_wdata = acc;
    end
    if (cmd.rd_pc) begin
      ram_raddr = pc[MemAW-1:0];
    end else if (cmd.rd_opr) begin
      ram_raddr = idx;
    end else begin
      ram_raddr = req_addr[MemAW-1:0];
    end
  end

  assign sts.clr_last     = (clr_addr == MemAW'(MemoryWords - 1));
  assign sts.stopped      = halted || (pc >= AddrW'(MemoryWords));
  assign sts.dec_busy     = (dec_phase != 2'd0);
  assign sts.div_busy     = dv_busy;
  assign sts.req_in_range = (req_addr < AddrW'(MemoryWords));
  // Only a divisor other than zero and minus one needs the serial divider.
  assign sts.is_div       = (opc_low == OP_DIV) && (mem_opr != '0) && (mem_opr != '1);

  assign mem_opr = ram_rdata;

  always_comb begin
    acc_next = acc;
    pc_next  = pc + AddrW'(1);
    unique case (opc_low)
      OP_LOAD: acc_next = mem_opr;
      OP_ADD:  acc_next = acc + mem_opr;
      OP_SUB:  acc_next = acc - mem_opr;
      OP_MUL:  acc_next = acc * mem_opr;
      OP_DIV: begin
        if (mem_opr == '1) acc_next = 32'd0 - acc;
      end
      OP_BR:   pc_next = AddrW'(idx);
      OP_BRNEG: begin
        if (acc[WordW-1]) pc_next = AddrW'(idx);
      end
      OP_BRZERO: begin
        if (acc == '0) pc_next = AddrW'(idx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      pc        <= '0;
      halted    <= 1'b0;
      clr_addr  <= '0;
      dec_phase <= 2'd0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + MemAW'(1);
      end
      if (cmd.restart) begin
        acc    <= '0;
        pc     <= '0;
        halted <= 1'b0;
      end else if (cmd.exec) begin
        acc <= acc_next;
        pc  <= pc_next;
        if (opc_low == OP_HALT) halted <= 1'b1;
      end else if (cmd.div_done) begin
        acc <= dv_q;
      end
      // The word is split by 100 in three steps: magnitude, reciprocal
      // product, then remainder and sign.
      if (cmd.dec_start) begin
        dec_phase <= 2'd1;
        dec_neg   <= ram_rdata[WordW-1];
        dec_mag   <= ram_rdata[WordW-1] ? (32'd0 - ram_rdata) : ram_rdata;
      end else if (dec_phase == 2'd1) begin
        dec_phase <= 2'd2;
        dec_quo   <= 25'(dec_prod >> 37);
      end else if (dec_phase == 2'd2) begin
        dec_phase <= 2'd0;
        opc       <= dec_neg ? (OpcW'(0) - OpcW'(dec_quo)) : OpcW'(dec_quo);
        opr       <= dec_neg ? (OprW'(0) - OprW'(dec_rem)) : OprW'(dec_rem);
        idx       <= dec_neg ? '0 : MemAW'(dec_rem);
      end
    end
  end

  // Request and result registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_addr <= address;
      req_data <= data_value;
      req_kind <= req_type;
    end
    if (cmd.rd_pc) begin
      pc_executed <= pc;
    end
    if (cmd.fin_ok || cmd.fin_read) begin
      pc_executed     <= AddrW'(MemoryWords);
      opcode_seen     <= '0;
      operand_seen    <= '0;
      out_valid       <= cmd.fin_read && sts.req_in_range;
      out_value       <= (cmd.fin_read && sts.req_in_range) ? ram_rdata : '0;
      status          <= (cmd.fin_ok && sts.stopped && req_kind == REQ_EXEC) ?
                         ST_STOPPED : ST_OK;
      accumulator_now <= cmd.restart ? '0 : acc;
    end
    if (cmd.exec) begin
      opcode_seen     <= opc;
      operand_seen    <= opr;
      out_valid       <= (opc_low == OP_WRITE);
      out_value       <= (opc_low == OP_WRITE) ? mem_opr : '0;
      accumulator_now <= acc_next;
      if (opc_low == OP_HALT) begin
        status <= ST_HALTED;
      end else if (opc_low == OP_DIV && mem_opr == '0) begin
        status <= ST_DIVZERO;
      end else if (opc != {20'd0, opc_low} || opc_low == '0 || !(
          opc_low == OP_READ || opc_low == OP_WRITE || opc_low == OP_LOAD ||
          opc_low == OP_STORE || opc_low == OP_ADD || opc_low == OP_SUB ||
          opc_low == OP_DIV || opc_low == OP_MUL || opc_low == OP_BR ||
          opc_low == OP_BRNEG || opc_low == OP_BRZERO)) begin
        status <= ST_INVALID;
      end else begin
        status <= ST_OK;
      end
    end
    if (cmd.div_done) begin
      accumulator_now <= dv_q;
    end
  end
endmodule

### hw/rtl/ams_ctrl.sv
`timescale 1ns / 1ps
module ams_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    req_type,
  input  ams_pkg::sts_t sts,
  output ams_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);
  import ams_pkg::*;

  state_t state, state_next;
  logic [1:0] req, req_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      req   <= REQ_LOAD;
    end else begin
      state <= state_next;
      req   <= req_next;
    end
  end

  always_comb begin
    state_next = state;
    req_next   = req;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          req_next    = req_type;
          state_next  = S_DATAREAD;
        end
      end
      S_DATAREAD: begin
        unique case (req)
          REQ_LOAD: begin
            cmd.wr_req = 1'b1;
            cmd.fin_ok = 1'b1;
            state_next = S_DONE;
          end
          REQ_READ: begin
            state_next = S_DATAWAIT;
          end
          REQ_RESTART: begin
            cmd.restart = 1'b1;
            cmd.fin_ok  = 1'b1;
            state_next  = S_DONE;
          end
          default: begin
            if (sts.stopped) begin
              cmd.fin_ok = 1'b1;
              state_next = S_DONE;
            end else begin
              cmd.rd_pc  = 1'b1;
              state_next = S_FETCH;
            end
          end
        endcase
      end
      S_DATAWAIT: begin
        cmd.fin_read = 1'b1;
        state_next   = S_DONE;
      end
      S_FETCH: begin
        cmd.dec_start = 1'b1;
        state_next    = S_DECODE;
      end
      S_DECODE: begin
        if (!sts.dec_busy) state_next = S_OPREAD;
      end
      S_OPREAD: begin
        cmd.rd_opr = 1'b1;
        state_next = S_OPWAIT;
      end
      S_OPWAIT: begin
        cmd.rd_opr = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        cmd.rd_opr = 1'b1;
        if (sts.is_div) begin
          state_next = S_DIVIDE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIVIDE: begin
        cmd.rd_opr    = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = S_DIVDONE;
      end
      S_DIVDONE: begin
        if (!sts.div_busy) begin
          cmd.div_done = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

### hw/rtl/accumulator_machine_step_core.sv
`timescale 1ns / 1ps
// Channel  | Ports                                              | Handshake
// request  | req_type, address, data_value                      | start, busy
// result   | pc_executed, opcode_seen, operand_seen,            | done
//          | accumulator_now, out_valid, out_value, status      |
// An instruction is fetched, then the word is split by 100 with a
// reciprocal multiply, then the operand is read. A divide instruction whose
// divisor is not zero or minus one adds the 32-step serial divider. After
// reset the memory is swept to zero, one word a cycle, over all MEMORY_WORDS
// words, with busy high. Results show for one cycle with done; they cannot
// be stalled.
module accumulator_machine_step_core #(
  parameter int unsigned MEMORY_WORDS = 100
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  output logic                              done,
  input  logic [1:0]                        req_type,
  input  logic [ams_pkg::AddrW-1:0]         address,
  input  logic signed [ams_pkg::WordW-1:0]  data_value,
  output logic [ams_pkg::AddrW-1:0]         pc_executed,
  output logic signed [ams_pkg::OpcW-1:0]   opcode_seen,
  output logic signed [ams_pkg::OprW-1:0]   operand_seen,
  output logic signed [ams_pkg::WordW-1:0]  accumulator_now,
  output logic                              out_valid,
  output logic signed [ams_pkg::WordW-1:0]  out_value,
  output logic [2:0]                        status
);
  import ams_pkg::*;
  `include "accumulator_machine_step_core_defines.svh"

  cmd_t cmd;
  sts_t sts;

  ams_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .req_type(req_type), .sts(sts),
    .cmd(cmd), .busy(busy), .done(done)
  );

  ams_datapath #(.MemoryWords(MEMORY_WORDS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .req_type(req_type),
    .address(address), .data_value(data_value), .pc_executed(pc_executed),
    .opcode_seen(opcode_seen), .operand_seen(operand_seen),
    .accumulator_now(accumulator_now), .out_valid(out_valid),
    .out_value(out_value), .status(status)
  );

  `AMS_ASSERT_NOW(a_done_busy, clk, rst, done, busy, "done while idle")
  `AMS_ASSERT_NEXT(a_done_idle, clk, rst, done, !busy, "no idle after done")
  `AMS_ASSERT_NOW(a_valid_status, clk, rst, done && out_valid,
                  status == ST_OK, "beat with data has bad status")
endmodule
